@@ hw/rtl/prefixed_integer_parser_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the prefixed integer parser
// Shared same-cycle and next-cycle implication forms with a common report.
// ----------------------------------------------------------------------------
`ifndef PREFIXED_INTEGER_PARSER_CORE_MACROS_SVH
`define PREFIXED_INTEGER_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PIP_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pip check failed");

// next-cycle implication, disabled in reset
`define PIP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pip check failed");

// next-cycle implication that also runs through reset
`define PIP_ASSERT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pip check failed");

`endif

@@ hw/rtl/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// Types, codes and helpers shared by the prefixed integer parser.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int WIDTH_DEF   = 32;
  localparam int MAX_LEN_DEF = 64;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic [1:0] RAD_DEC = 2'd0;
  localparam logic [1:0] RAD_HEX = 2'd1;
  localparam logic [1:0] RAD_BIN = 2'd2;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam logic [4:0] NO_DIGIT  = 5'd16;

  typedef struct packed {
    logic [7:0]  ch;
    logic        start_req;
    logic [31:0] rel_base;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [6:0]  length;
  } result_t;

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
    return d;
  endfunction

  function automatic logic [4:0] radix_of(input logic [1:0] sel);
    logic [4:0] r;
    unique case (sel)
      RAD_HEX: r = 5'd16;
      RAD_BIN: r = 5'd2;
      default: r = 5'd10;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/prefixed_integer_parser_core.sv @@
// ----------------------------------------------------------------------------
// prefixed_integer_parser_core
// Character-stream parser for unsigned numbers with r, 0x and 0b prefixes.
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | ch, start_req, rel_base
//   output  | out_valid / out_ready| value, status, length
//
// One character per cycle while the parser is not blocked; a result is offered once its
// terminator has passed through the input register and then the result register.
// The shift-add accumulate and prefix decode sit between the two registers.
// rst clears the phase and both valid flags; data registers are not reset.
// A waiting result blocks the parser: no character leaves the input register
// until the result transfers, and in_ready drops once that register is full.
module prefixed_integer_parser_core
  import pip_pkg::*;
#(
  parameter int WIDTH   = WIDTH_DEF,
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        start_req,
  input  logic [31:0] rel_base,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [1:0]  status,
  output logic [6:0]  length
);

  item_t   item;
  logic    item_valid;
  logic    take;
  logic    slot_free;
  logic    res_valid;
  result_t res;

  pip_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .start_req  (start_req),
    .rel_base   (rel_base),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  pip_parse #(
    .WIDTH   (WIDTH),
    .MAX_LEN (MAX_LEN)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .slot_free  (slot_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  pip_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status),
    .length    (length)
  );

endmodule

@@ hw/rtl/pip_in_stage.sv @@
// ----------------------------------------------------------------------------
// pip_in_stage
// Input register: holds one accepted character until the parser takes it.
// ----------------------------------------------------------------------------
module pip_in_stage
  import pip_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        start_req,
  input  logic [31:0] rel_base,
  input  logic        take,
  output logic        item_valid,
  output item_t       item
);

  always_comb begin
    in_ready = !item_valid || take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.ch        <= ch;
      item.start_req <= start_req;
      item.rel_base  <= rel_base;
    end
  end

endmodule

@@ hw/rtl/pip_parse.sv @@
// ----------------------------------------------------------------------------
// pip_parse
// Parser state and datapath: prefix decode, shift-add accumulate, result build.
// ----------------------------------------------------------------------------
module pip_parse
  import pip_pkg::*;
#(
  parameter int WIDTH   = WIDTH_DEF,
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  input  logic    slot_free,
  output logic    take,
  output logic    res_valid,
  output result_t res
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  logic [1:0]       phase, phase_next;
  logic [1:0]       radix_sel, radix_sel_next;
  logic [WIDTH-1:0] acc, acc_next;
  logic             rel_mode, rel_mode_next;
  logic [31:0]      base, base_next;
  logic             ovf, ovf_next;
  logic [6:0]       count, count_next;

  logic [4:0]       digit;
  logic [1:0]       eff_sel;
  logic [WIDTH+4:0] acc_wide;
  logic [WIDTH+4:0] prod;
  logic [WIDTH+4:0] sum;
  logic             acc_ovf;
  logic [WIDTH-1:0] acc_step;
  logic             ovf_step;
  logic [6:0]       count_inc;
  logic [WIDTH-1:0] done_sum;
  logic [7:0]       ch_fold;

  assign take    = item_valid && slot_free;
  assign digit   = digit_of(item.ch);
  assign ch_fold = item.ch | CASE_BIT;
  assign eff_sel = (phase == PH_ZERO) ? RAD_DEC : radix_sel;
  assign acc_wide = (WIDTH+5)'(acc);

  always_comb begin
    unique case (eff_sel)
      RAD_HEX: prod = acc_wide << 4;
      RAD_BIN: prod = acc_wide << 1;
      default: prod = (acc_wide << 3) + (acc_wide << 1);
    endcase
  end

  assign sum       = prod + (WIDTH+5)'(digit[3:0]);
  assign acc_ovf   = |sum[WIDTH+4:WIDTH];
  assign acc_step  = (ovf || acc_ovf) ? acc : sum[WIDTH-1:0];
  assign ovf_step  = ovf || acc_ovf;
  assign count_inc = (count < 7'(MAX_LEN)) ? count + 7'd1 : count;
  assign done_sum  = acc + (rel_mode ? WIDTH'(base) : '0);

  always_comb begin
    phase_next     = phase;
    radix_sel_next = radix_sel;
    acc_next       = acc;
    rel_mode_next  = rel_mode;
    base_next      = base;
    ovf_next       = ovf;
    count_next     = count;
    res_valid      = 1'b0;
    res.value      = '1;
    res.status     = ST_BAD;
    res.length     = '0;
    if (take) begin
      if (item.start_req) begin
        base_next      = item.rel_base;
        radix_sel_next = RAD_DEC;
        acc_next       = '0;
        rel_mode_next  = 1'b0;
        ovf_next       = 1'b0;
        count_next     = 7'd1;
        if (item.ch >= CH_1 && item.ch <= CH_9) begin
          acc_next   = WIDTH'(digit[3:0]);
          phase_next = PH_DIGITS;
        end else if (item.ch == CH_0 || ch_fold == CH_R) begin
          rel_mode_next = (item.ch != CH_0);
          phase_next    = PH_ZERO;
        end else begin
          count_next = '0;
          res_valid  = 1'b1;
          phase_next = PH_IDLE;
        end
      end else begin
        unique case (phase)
          PH_ZERO: begin
            phase_next = PH_DIGITS;
            count_next = count_inc;
            if (digit < 5'd10) begin
              radix_sel_next = RAD_DEC;
              acc_next       = acc_step;
              ovf_next       = ovf_step;
            end else if (ch_fold == CH_X) begin
              radix_sel_next = RAD_HEX;
            end else if (ch_fold == CH_B) begin
              radix_sel_next = RAD_BIN;
            end else begin
              count_next = count;
              res_valid  = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          PH_DIGITS: begin
            if (digit >= radix_of(radix_sel)) begin
              res_valid  = 1'b1;
              phase_next = PH_IDLE;
              res.length = count;
              if (ovf) begin
                res.status = ST_OVF;
              end else begin
                res.value  = 32'(done_sum);
                res.status = ST_OK;
              end
            end else begin
              acc_next   = acc_step;
              ovf_next   = ovf_step;
              count_next = count_inc;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    radix_sel <= radix_sel_next;
    acc       <= acc_next;
    rel_mode  <= rel_mode_next;
    base      <= base_next;
    ovf       <= ovf_next;
    count     <= count_next;
  end

endmodule

@@ hw/rtl/pip_out_stage.sv @@
// ----------------------------------------------------------------------------
// pip_out_stage
// Result register: holds one result until the consumer completes the transfer.
// ----------------------------------------------------------------------------
module pip_out_stage
  import pip_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        slot_free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [1:0]  status,
  output logic [6:0]  length
);

  result_t held;

  assign slot_free = !out_valid || out_ready;
  assign value     = held.value;
  assign status    = held.status;
  assign length    = held.length;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      held <= res;
    end
  end

endmodule

@@ hw/rtl/pip_checker.sv @@
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks on the parser results, bound to the top level.
// ----------------------------------------------------------------------------
`include "prefixed_integer_parser_core_macros.svh"

module pip_checker
  import pip_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value,
  input logic [1:0]  status,
  input logic [6:0]  length
);

  logic        out_hold;
  logic        status_known;
  logic        value_ones;
  logic [40:0] out_word;

  assign out_hold     = out_valid && !out_ready;
  assign status_known = status == ST_OK || status == ST_BAD || status == ST_OVF;
  assign value_ones   = value == 32'hFFFF_FFFF;
  assign out_word     = {value, status, length};

  `PIP_ASSERT_ALWAYS(a_reset_clears_out, clk, rst, !out_valid)
  `PIP_ASSERT_NEXT(a_out_holds, clk, rst, out_hold, out_valid && $stable(out_word))
  `PIP_ASSERT_NOW(a_status_code, clk, rst, out_valid, status_known)
  `PIP_ASSERT_NOW(a_bad_shape, clk, rst, out_valid && status == ST_BAD, value_ones && length == 7'd0)
  `PIP_ASSERT_NOW(a_ovf_value, clk, rst, out_valid && status == ST_OVF, value_ones && length != 7'd0)

endmodule

bind prefixed_integer_parser_core pip_checker u_pip_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value),
  .status    (status),
  .length    (length)
);
